[hdl/size_class_slab_allocator_top_macros.svh]
// ----------------------------------------------------------------------------
// size_class_slab_allocator_top_macros
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef SIZE_CLASS_SLAB_ALLOCATOR_TOP_MACROS_SVH
`define SIZE_CLASS_SLAB_ALLOCATOR_TOP_MACROS_SVH

// Implication checked every clock edge outside reset.
`define SCSA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define SCSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/scsa_pkg.sv]
// ----------------------------------------------------------------------------
// scsa_pkg
// Shared types and constants of the size-class slab allocator.
// ----------------------------------------------------------------------------
package scsa_pkg;
    localparam int NUM_CLASSES   = 8;
    localparam int POOL_PAGES    = 16;
    localparam int MAX_PAGE_LOG2 = 12;
    localparam int MIN_SLOT_LOG2 = 3;
    localparam int LINK_SHIFT    = MAX_PAGE_LOG2 - MIN_SLOT_LOG2;
    localparam int LINK_DEPTH    = POOL_PAGES << LINK_SHIFT;
    localparam int IDX_W         = $clog2(LINK_DEPTH);
    localparam int CLS_W         = $clog2(NUM_CLASSES);
    localparam int PG_W          = $clog2(POOL_PAGES + 1);
    localparam int TABLE_CLASSES = (NUM_CLASSES < 8) ? NUM_CLASSES : 8;

    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_HEAP = 3'd1;
    localparam logic [2:0] ST_OOM  = 3'd2;
    localparam logic [2:0] ST_BIG  = 3'd3;
    localparam logic [2:0] ST_NULL = 3'd4;

    localparam logic [1:0] CFG_PAGE  = 2'd0;
    localparam logic [1:0] CFG_COUNT = 2'd1;
    localparam logic [1:0] CFG_TABLE = 2'd2;

    localparam logic [31:0] SIZE_LIMIT = 32'h7FFF_FFFF;

    typedef struct packed {
        logic req_type;
        logic [31:0] size;
        logic [15:0] address;
        logic null_pointer;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] slot_address;
        logic [31:0] granted_size;
        logic [63:0] total_bytes;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture request and classify
        logic carve_init; // start carving a page
        logic carve_step; // push one carved slot
        logic rd_link;    // read link of head
        logic pop;        // commit pop
        logic push_free;  // commit free push
        logic finish;     // build result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_alloc_path; // allocate hitting a class
        logic is_free_push;  // free of exact class size
        logic head_valid;
        logic can_carve;
        logic carve_last;
        logic carve_none;    // page yields no slot
    } t_sts;
endpackage

[hdl/scsa_stream_if.sv]
// ----------------------------------------------------------------------------
// scsa_stream_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface scsa_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/size_class_slab_allocator_top.sv]
// Sequence: an accepted request is decoded; an allocate served from a class list
// then reads the link memory, pops and builds the result, while every other request
// goes straight to building the result. A page carved first adds one carve step per
// slot (up to 512). Only one request is in flight: a new one is accepted only after
// the response of the last has been taken.
// Reset: synchronous active low; all free lists empty, no pages used, total 0.
// ----------------------------------------------------------------------------
// size_class_slab_allocator_top
// Slab allocator top level: controller plus datapath.
// ----------------------------------------------------------------------------
module size_class_slab_allocator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    scsa_stream_if.sink   req_if,
    scsa_stream_if.source rsp_if
);
    import scsa_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    t_rsp w_rsp;

    // sequence one request at a time
    scsa_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(req_if.valid), .o_in_ready(req_if.ready),
        .o_out_valid(rsp_if.valid), .i_out_ready(rsp_if.ready),
        .i_sts(w_sts), .o_cmd(w_cmd)
    );

    // hold state and build the response
    scsa_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_req(req_if.data), .i_cmd(w_cmd), .o_sts(w_sts), .o_rsp(w_rsp)
    );

    assign rsp_if.data = w_rsp;
endmodule

[hdl/scsa_datapath.sv]
// ----------------------------------------------------------------------------
// scsa_datapath
// Class lookup, free lists, link memory, page carving and byte total.
// ----------------------------------------------------------------------------
module scsa_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  scsa_pkg::t_req     i_req,
    input  scsa_pkg::t_cmd     i_cmd,
    output scsa_pkg::t_sts     o_sts,
    output scsa_pkg::t_rsp     o_rsp
);
    import scsa_pkg::*;

    logic [3:0]  r_page_log2, r_count;
    logic [31:0] r_table;
    logic [IDX_W-1:0] r_link [LINK_DEPTH];
    logic [IDX_W-1:0] r_head [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] r_hv;
    logic [PG_W-1:0] r_pages;
    logic [63:0] r_total;
    t_req r_req;
    logic [CLS_W-1:0] r_cls;
    logic r_hit, r_exact, r_big;
    logic [3:0] r_sl;
    logic [IDX_W-1:0] r_cidx, r_cend, r_step, r_link_q;
    // pop success flag captured at pop time
    logic r_hv_ok;

    function automatic logic [3:0] cls_log2(input logic [31:0] t, input int c);
        logic [3:0] l;
        l = t[4*c +: 4];
        return (l < 4'(MIN_SLOT_LOG2)) ? 4'(MIN_SLOT_LOG2) : l;
    endfunction

    // first fitting class
    logic [CLS_W-1:0] w_cls;
    logic w_hit;
    logic [3:0] w_n;
    always_comb begin
        w_cls = '0;
        w_hit = 1'b0;
        w_n = (r_count > 4'(TABLE_CLASSES)) ? 4'(TABLE_CLASSES) : r_count;
        for (int c = TABLE_CLASSES - 1; c >= 0; c--) begin
            if (4'(c) < w_n && (33'd1 << cls_log2(r_table, c)) >= {1'b0, i_req.size}) begin
                w_cls = CLS_W'(c);
                w_hit = 1'b1;
            end
        end
    end

    logic [3:0] w_pl;
    assign w_pl = (r_page_log2 > 4'(MAX_PAGE_LOG2)) ? 4'(MAX_PAGE_LOG2) : r_page_log2;
    logic [IDX_W-1:0] w_hidx, w_fidx;
    assign w_hidx = r_head[r_cls];
    assign w_fidx = IDX_W'(r_req.address >> MIN_SLOT_LOG2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_log2 <= 4'd12;
            r_count <= 4'd8;
            r_table <= 32'hA987_6543;
            r_hv <= '0;
            r_pages <= '0;
            r_total <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_PAGE:  r_page_log2 <= i_cfg_data[3:0];
                    CFG_COUNT: r_count <= i_cfg_data[3:0];
                    CFG_TABLE: r_table <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.carve_init) r_pages <= r_pages + PG_W'(1);
            if (i_cmd.carve_step || i_cmd.push_free) r_hv[r_cls] <= 1'b1;
            if (i_cmd.pop && r_link_q == w_hidx) r_hv[r_cls] <= 1'b0;
            if (i_cmd.finish) begin
                if (!r_req.req_type) begin
                    if (!r_big && !r_hit) r_total <= r_total + 64'(r_req.size);
                    else if (!r_big && r_hv_ok) r_total <= r_total + (64'd1 << r_sl);
                end else if (!r_req.null_pointer) begin
                    r_total <= r_total - 64'(r_req.size);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_hv_ok <= 1'b0;
        else if (i_cmd.load) r_hv_ok <= 1'b0;
        else if (i_cmd.pop) r_hv_ok <= 1'b1;
    end

    logic [IDX_W-1:0] r_pop_idx;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
            r_cls <= w_cls;
            r_hit <= w_hit;
            r_sl <= cls_log2(r_table, int'(w_cls));
            r_exact <= w_hit && ((33'd1 << cls_log2(r_table, int'(w_cls))) == {1'b0, i_req.size});
            r_big <= i_req.size > SIZE_LIMIT;
        end
        if (i_cmd.carve_init) begin
            r_cidx <= IDX_W'(32'(r_pages) << LINK_SHIFT);
            r_step <= IDX_W'(1) << (r_sl - 4'(MIN_SLOT_LOG2));
            r_cend <= IDX_W'(32'(r_pages) << LINK_SHIFT)
                    + IDX_W'((32'd1 << (w_pl - 4'(MIN_SLOT_LOG2))) - (32'd1 << (r_sl - 4'(MIN_SLOT_LOG2))));
        end
        if (i_cmd.carve_step) begin
            r_cidx <= r_cidx + r_step;
            r_head[r_cls] <= r_cidx;
            r_link[r_cidx] <= r_hv[r_cls] ? w_hidx : r_cidx;
        end
        if (i_cmd.push_free) begin
            r_head[r_cls] <= w_fidx;
            r_link[w_fidx] <= r_hv[r_cls] ? w_hidx : w_fidx;
        end
        if (i_cmd.rd_link) r_link_q <= r_link[w_hidx];
        if (i_cmd.pop) begin
            r_pop_idx <= w_hidx;
            if (r_link_q != w_hidx) r_head[r_cls] <= r_link_q;
        end
    end

    assign o_sts.is_alloc_path = !r_req.req_type && !r_big && r_hit;
    assign o_sts.is_free_push  = r_req.req_type && !r_req.null_pointer && r_exact;
    assign o_sts.head_valid    = r_hv[r_cls];
    assign o_sts.can_carve     = r_pages < PG_W'(POOL_PAGES);
    assign o_sts.carve_last    = r_cidx == r_cend;
    assign o_sts.carve_none    = r_sl > w_pl;

    always_comb begin
        o_rsp = '0;
        o_rsp.total_bytes = r_total;
        if (!r_req.req_type) begin
            if (r_big) o_rsp.status = ST_BIG;
            else if (!r_hit) begin
                o_rsp.status = ST_HEAP;
                o_rsp.granted_size = r_req.size;
            end else if (r_hv_ok) begin
                o_rsp.status = ST_OK;
                o_rsp.slot_address = 16'(32'(r_pop_idx) << MIN_SLOT_LOG2);
                o_rsp.granted_size = 32'd1 << r_sl;
            end else o_rsp.status = ST_OOM;
        end else if (r_req.null_pointer) o_rsp.status = ST_NULL;
        else if (r_exact) begin
            o_rsp.status = ST_OK;
            o_rsp.slot_address = r_req.address;
            o_rsp.granted_size = r_req.size;
        end else begin
            o_rsp.status = ST_HEAP;
            o_rsp.granted_size = r_req.size;
        end
    end
endmodule

[hdl/scsa_ctrl.sv]
// ----------------------------------------------------------------------------
// scsa_ctrl
// Sequencer of one request: classify, carve, pop or push, respond.
// ----------------------------------------------------------------------------
module scsa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  scsa_pkg::t_sts i_sts,
    output scsa_pkg::t_cmd o_cmd
);
    import scsa_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_CARVE = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_POP   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: if (i_in_valid) begin
                o_cmd.load = 1'b1;
                n_state = S_DEC;
            end
            S_DEC: begin
                if (i_sts.is_alloc_path) begin
                    if (i_sts.head_valid) n_state = S_RD;
                    else if (i_sts.can_carve && !i_sts.carve_none) begin
                        o_cmd.carve_init = 1'b1;
                        n_state = S_CARVE;
                    end else begin
                        o_cmd.carve_init = i_sts.can_carve;
                        n_state = S_FIN;
                    end
                end else begin
                    o_cmd.push_free = i_sts.is_free_push;
                    n_state = S_FIN;
                end
            end
            S_CARVE: begin
                o_cmd.carve_step = 1'b1;
                if (i_sts.carve_last) n_state = S_RD;
            end
            S_RD: begin
                o_cmd.rd_link = 1'b1;
                n_state = S_POP;
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_state == S_OUT;
endmodule

[hdl/scsa_checker.sv]
// ----------------------------------------------------------------------------
// scsa_checker
// Port-level checks of the allocator.
// ----------------------------------------------------------------------------
`include "size_class_slab_allocator_top_macros.svh"
module scsa_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic [2:0] i_status
);
    import scsa_pkg::*;
    `SCSA_ASSERT_IMP(a_one_at_a_time, i_clk, i_rst_n, i_out_valid, !i_in_ready, "busy accept")
    `SCSA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "no stall")
    `SCSA_ASSERT_IMP(a_status_range, i_clk, i_rst_n, i_out_valid, i_status <= ST_NULL, "bad status")
    `SCSA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "drop")
endmodule

bind size_class_slab_allocator_top scsa_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(req_if.valid), .i_in_ready(req_if.ready),
    .i_out_valid(rsp_if.valid), .i_out_ready(rsp_if.ready),
    .i_status(rsp_if.data.status)
);

[sim/tb_size_class_slab_allocator_top.sv]
// ----------------------------------------------------------------------------
// tb_size_class_slab_allocator_top
// Self-checking bench for the slab allocator. A short directed table opens
// the run, then random allocate/free traffic under several register settings.
// Responses to the first directed rows are checked against typed values, all others
// against an internal model of the free lists, page carving and the running byte total.
// ----------------------------------------------------------------------------
module tb_size_class_slab_allocator_top;
    import scsa_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int STALL_LIMIT   = 20000;
    localparam int ITEMS_PER_SET = 210;
    localparam int DRAIN_CYCLES  = 600;

    typedef struct {
        t_req req;
        bit   has_typed;
        t_rsp typed;
    } t_dir_row;

    typedef struct {
        logic [15:0] addr;
        logic [31:0] size;
    } t_live_slot;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [31:0] i_cfg_data;

    scsa_stream_if #(.T(t_req)) req_if ();
    scsa_stream_if #(.T(t_rsp)) rsp_if ();

    size_class_slab_allocator_top dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .req_if    (req_if),
        .rsp_if    (rsp_if)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Model state: link memory, per-class list heads, pages carved, byte total
    logic [IDX_W-1:0] link_mem [LINK_DEPTH];
    logic [IDX_W-1:0] list_head [NUM_CLASSES];
    bit               list_live [NUM_CLASSES];
    int               pages_carved;
    logic [63:0]      byte_total;

    // Model copy of the registers
    logic [3:0]  page_log2_reg;
    logic [3:0]  class_count_reg;
    logic [31:0] class_table_reg;

    t_rsp       pending_rsp [$];
    t_live_slot live_slots [$];
    t_dir_row   dir_rows [$];
    int         fail_count;
    int         idle_cycles;
    bit         calm_sender;
    bit         calm_receiver;
    int         rsp_stall_left;

    // ------------------------------------------------------------------
    // Allocator model
    // ------------------------------------------------------------------
    function automatic int slot_log2(int c);
        logic [3:0] nib;
        nib = class_table_reg[4*c +: 4];
        return (nib < MIN_SLOT_LOG2) ? MIN_SLOT_LOG2 : int'(nib);
    endfunction

    function automatic int active_classes();
        return (class_count_reg > TABLE_CLASSES) ? TABLE_CLASSES : int'(class_count_reg);
    endfunction

    // first class in table order that holds sz, -1 when none does
    function automatic int pick_class(logic [63:0] sz);
        for (int c = 0; c < active_classes(); c++)
            if ((64'd1 << slot_log2(c)) >= sz)
                return c;
        return -1;
    endfunction

    function automatic void push_free(int c, logic [IDX_W-1:0] idx);
        // the bottom of a list links to itself
        link_mem[idx] = list_live[c] ? list_head[c] : idx;
        list_head[c]  = idx;
        list_live[c]  = 1'b1;
    endfunction

    function automatic void carve_page(int c);
        int pl;
        int sl;
        int n;
        int base;
        if (pages_carved >= POOL_PAGES)
            return;
        pl   = (page_log2_reg > MAX_PAGE_LOG2) ? MAX_PAGE_LOG2 : int'(page_log2_reg);
        sl   = slot_log2(c);
        base = (pages_carved << MAX_PAGE_LOG2) >> MIN_SLOT_LOG2;
        // a page smaller than the slot is consumed with nothing to show
        n    = (sl <= pl) ? (1 << (pl - sl)) : 0;
        for (int i = 0; i < n; i++)
            push_free(c, IDX_W'((base + (i << (sl - MIN_SLOT_LOG2))) % LINK_DEPTH));
        pages_carved++;
    endfunction

    function automatic t_rsp allocator_response(t_req r);
        t_rsp             o;
        int               c;
        logic [IDX_W-1:0] idx;
        logic [63:0]      sz;
        o  = '0;
        sz = {32'd0, r.size};
        if (!r.req_type) begin
            if (r.size > SIZE_LIMIT) begin
                o.status = ST_BIG;
            end else begin
                c = pick_class(sz);
                if (c < 0) begin
                    o.status       = ST_HEAP;
                    o.granted_size = r.size;
                    byte_total     = byte_total + sz;
                end else begin
                    if (!list_live[c])
                        carve_page(c);
                    if (!list_live[c]) begin
                        o.status = ST_OOM;
                    end else begin
                        idx = list_head[c];
                        if (link_mem[idx] == idx)
                            list_live[c] = 1'b0;
                        else
                            list_head[c] = link_mem[idx];
                        o.status       = ST_OK;
                        o.slot_address = 16'(idx) << MIN_SLOT_LOG2;
                        o.granted_size = 32'd1 << slot_log2(c);
                        byte_total     = byte_total + {32'd0, o.granted_size};
                    end
                end
            end
        end else if (r.null_pointer) begin
            o.status = ST_NULL;
        end else begin
            c          = pick_class(sz);
            byte_total = byte_total - sz;
            if (c >= 0 && (64'd1 << slot_log2(c)) == sz) begin
                push_free(c, IDX_W'(r.address >> MIN_SLOT_LOG2));
                o.status       = ST_OK;
                o.slot_address = r.address;
            end else begin
                o.status = ST_HEAP;
            end
            o.granted_size = r.size;
        end
        o.total_bytes = byte_total;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_PAGE:  page_log2_reg   = data[3:0];
            CFG_COUNT: class_count_reg = data[3:0];
            CFG_TABLE: class_table_reg = data;
            default: ;
        endcase
    endtask

    // Hand one request to the block; queue the typed result if given, else the model's
    task automatic send_request(t_req r, bit has_typed, t_rsp typed);
        t_rsp       model;
        t_live_slot held;
        int         gap;
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        model = allocator_response(r);
        pending_rsp.insert(pending_rsp.size(), has_typed ? typed : model);
        if (!r.req_type && model.status == ST_OK) begin
            held.addr = model.slot_address;
            held.size = model.granted_size;
            live_slots.insert(live_slots.size(), held);
        end
        gap = calm_sender ? 0 : gap_len();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic add_row(bit rt, logic [31:0] sz, logic [15:0] addr, bit nul, bit has,
                           logic [2:0] st, logic [15:0] slot, logic [31:0] gr,
                           logic [63:0] tot);
        t_dir_row row;
        row.req       = '{rt, sz, addr, nul};
        row.has_typed = has;
        row.typed     = '{st, slot, gr, tot};
        dir_rows.insert(dir_rows.size(), row);
    endtask

    // Well-formed traffic mostly: allocations sized to the classes in use and frees of
    // live slots; the rest is noise over the whole field range
    function automatic t_req random_request();
        t_req       r;
        int         roll;
        int         c;
        int         pick;
        logic [31:0] top;
        r    = '{1'b0, $urandom, 16'($urandom), 1'($urandom)};
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            r.req_type = 1'b0;
            if (active_classes() > 0 && $urandom_range(0, 9) != 0) begin
                c   = $urandom_range(0, active_classes() - 1);
                top = 32'd1 << slot_log2(c);
                r.size = $urandom_range(0, 1) ? top : $urandom_range(0, top);
            end else begin
                r.size = $urandom_range(0, 1 << $urandom_range(0, 20));
            end
        end else if (roll < 85 && live_slots.size() > 0) begin
            pick       = $urandom_range(0, live_slots.size() - 1);
            r.req_type = 1'b1;
            r.address  = live_slots[pick].addr;
            r.size     = live_slots[pick].size;
            r.null_pointer = 1'b0;
            live_slots.delete(pick);
        end else if (roll < 92) begin
            r.req_type = 1'b1;
            r.size     = 32'd1 << $urandom_range(0, 16);
        end
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_rsp.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Response side: random back-pressure and checking
    // ------------------------------------------------------------------
    task automatic report_field(string name, logic [63:0] want, logic [63:0] got);
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready   <= 1'b0;
            rsp_stall_left = 0;
        end else if (rsp_stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_stall_left--;
        end else begin
            rsp_if.ready <= 1'b1;
            if (!calm_receiver && $urandom_range(0, 3) == 0)
                rsp_stall_left = gap_len();
        end
    end

    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.data;
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected response, status %0d", $time, got.status);
                fail_count++;
            end else begin
                want = pending_rsp.pop_front();
                if (got.status !== want.status)
                    report_field("status", 64'(want.status), 64'(got.status));
                if (got.slot_address !== want.slot_address)
                    report_field("slot_address", 64'(want.slot_address),
                                 64'(got.slot_address));
                if (got.granted_size !== want.granted_size)
                    report_field("granted_size", 64'(want.granted_size),
                                 64'(got.granted_size));
                if (got.total_bytes !== want.total_bytes)
                    report_field("total_bytes", want.total_bytes, got.total_bytes);
            end
        end
    end

    // Watchdog: give up when nothing moves on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress, %0d responses outstanding", $time,
                         pending_rsp.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [31:0] set_page [8];
        logic [31:0] set_count [8];
        logic [31:0] set_table [8];
        t_rsp        none;
        none = '0;

        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= CFG_PAGE;
        i_cfg_data   <= '0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        fail_count   = 0;
        idle_cycles  = 0;
        calm_sender   = 1'b0;
        calm_receiver = 1'b0;
        pages_carved  = 0;
        byte_total    = '0;
        foreach (list_live[c]) begin
            list_live[c] = 1'b0;
            list_head[c] = '0;
        end
        foreach (link_mem[i])
            link_mem[i] = '0;

        // Settings: reset values, extremes, capped values, low nibbles, empty class list
        set_page  = '{32'd12, 32'd3, 32'd15, 32'd6, 32'd9, 32'd12, 32'd10, 32'd3};
        set_count = '{32'd8, 32'd1, 32'd15, 32'd0, 32'd4, 32'd8, 32'd3, 32'd8};
        set_table = '{32'hA987_6543, 32'h0000_0003, 32'hFFFF_FFFF, 32'h0000_0000,
                      32'h0000_7543, 32'hBA98_6420, 32'h0000_0964, 32'h7654_3333};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset settings. Class 0 holds 8 bytes, the top class
        // 1024; the first carve fills page 0 and hands out its highest slot first.
        add_row(0, 32'd0,         16'h0000, 0, 1, ST_OK,   16'h0FF8, 32'd8,    64'd8);
        add_row(0, 32'h8000_0000, 16'h0000, 0, 1, ST_BIG,  16'h0000, 32'd0,    64'd8);
        add_row(0, 32'hFFFF_FFFF, 16'hFFFF, 1, 1, ST_BIG,  16'h0000, 32'd0,    64'd8);
        add_row(1, 32'd8,         16'hFFFF, 1, 1, ST_NULL, 16'h0000, 32'd0,    64'd8);
        add_row(0, 32'd2048,      16'h0000, 0, 1, ST_HEAP, 16'h0000, 32'd2048, 64'd2056);
        add_row(1, 32'd2048,      16'h0000, 0, 1, ST_HEAP, 16'h0000, 32'd2048, 64'd8);
        add_row(0, 32'd1024,      16'h0000, 0, 1, ST_OK,   16'h1C00, 32'd1024, 64'd1032);
        add_row(1, 32'd1024,      16'h1C00, 0, 1, ST_OK,   16'h1C00, 32'd1024, 64'd8);
        add_row(0, 32'd8,         16'h0000, 0, 1, ST_OK,   16'h0FF0, 32'd8,    64'd16);
        // model-checked rows: boundaries between classes, odd addresses, wrap of total
        add_row(0, 32'd9,         16'h0000, 1, 0, 0, 0, 0, 0);
        add_row(0, 32'd1,         16'h0000, 0, 0, 0, 0, 0, 0);
        add_row(0, 32'd16,        16'h0000, 0, 0, 0, 0, 0, 0);
        add_row(0, 32'd17,        16'h0000, 0, 0, 0, 0, 0, 0);
        add_row(0, 32'd512,       16'h0000, 0, 0, 0, 0, 0, 0);
        add_row(0, 32'd1025,      16'h0000, 0, 0, 0, 0, 0, 0);
        add_row(0, 32'h7FFF_FFFF, 16'h0000, 0, 0, 0, 0, 0, 0);
        add_row(1, 32'h7FFF_FFFF, 16'h0000, 0, 0, 0, 0, 0, 0);
        add_row(1, 32'd8,         16'hFFFF, 0, 0, 0, 0, 0, 0);
        add_row(0, 32'd8,         16'h0000, 0, 0, 0, 0, 0, 0);
        add_row(1, 32'd0,         16'h1234, 0, 0, 0, 0, 0, 0);
        add_row(1, 32'd16,        16'h0FF3, 0, 0, 0, 0, 0, 0);
        add_row(1, 32'hFFFF_FFFF, 16'h0000, 0, 0, 0, 0, 0, 0);
        add_row(0, 32'd16,        16'h0000, 0, 0, 0, 0, 0, 0);

        for (int s = 0; s < 8; s++) begin
            write_reg(CFG_PAGE, set_page[s]);
            write_reg(CFG_COUNT, set_count[s]);
            write_reg(CFG_TABLE, set_table[s]);
            if (s == 0) begin
                foreach (dir_rows[i])
                    send_request(dir_rows[i].req, dir_rows[i].has_typed, dir_rows[i].typed);
            end
            // alternate between full-rate stretches and random gaps
            calm_sender   = (s % 3 == 1);
            calm_receiver = (s % 4 == 2);
            for (int n = 0; n < ITEMS_PER_SET; n++)
                send_request(random_request(), 1'b0, none);
            req_if.valid <= 1'b0;
            calm_sender   = 1'b0;
            calm_receiver = 1'b0;
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_rsp.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
